FILE: hw/rtl/qat_pkg.sv
// Shared types and constants for the quoted argument tokenizer.
// Used by qat_step, qat_outq and quoted_argument_tokenizer; depends on nothing.
package qat_pkg;

  localparam int MAX_ARGS_DEF = 31;
  localparam int CNT_W        = 6;   // internal argument counter, holds up to 63
  localparam int IDX_W        = 5;   // width of arg_index / arg_count on the ports
  localparam int Q_DEPTH      = 4;
  localparam int QPTR_W       = 2;
  localparam int QCNT_W       = 3;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [4:0] {
    M_SKIP   = 5'b00001,
    M_PLAIN  = 5'b00010,
    M_QUOTED = 5'b00100,
    M_AFTER  = 5'b01000,
    M_DROP   = 5'b10000
  } mode_t;

  typedef enum logic [1:0] {
    R_BYTE   = 2'd0,
    R_END    = 2'd1,
    R_ACCEPT = 2'd2,
    R_REJECT = 2'd3
  } rtype_t;

  typedef enum logic [1:0] {
    E_NONE    = 2'd0,
    E_STRAY   = 2'd1,
    E_AFTER   = 2'd2,
    E_MISSING = 2'd3
  } err_t;

  typedef struct packed {
    rtype_t             result_type;
    logic [7:0]         out_char;
    logic [IDX_W-1:0]   arg_index;
    err_t               error_code;
    logic [IDX_W-1:0]   arg_count;
    logic               last;
  } res_t;

  // Up to two results come out of one item: an argument end and an accept.
  typedef struct packed {
    logic r0_vld;
    logic r1_vld;
    res_t r0;
    res_t r1;
  } step_out_t;

endpackage

FILE: hw/rtl/qat_step.sv
// Tokenizer state and the per-byte update that produces up to two results.
// Depends on qat_pkg.
module qat_step import qat_pkg::*; #(
  parameter int MAX_ARGS = MAX_ARGS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       proc,
  input  logic [7:0] ch,
  output step_out_t  so
);

  mode_t            mode_r, mode_nxt;
  logic             esc_r, esc_nxt;
  logic             has_r, has_nxt;
  logic [CNT_W-1:0] done_r, done_nxt;

  logic [CNT_W-1:0] done_inc, done_f;
  logic             nul, blank, quote, bslash, lim;
  logic             do_fin, fin_zero, do_rej, rej_zero;
  err_t             rej_code;
  res_t             byte_res, end_res, acc_res, rej_res;

  assign nul      = (ch == CH_NUL);
  assign blank    = (ch == CH_SPACE) || (ch == CH_TAB);
  assign quote    = (ch == CH_QUOTE);
  assign bslash   = (ch == CH_BSLASH);
  assign done_inc = done_r + 1'b1;
  assign done_f   = has_r ? done_inc : done_r;
  assign lim      = done_f >= CNT_W'(MAX_ARGS);

  always_comb begin
    byte_res             = '0;
    byte_res.result_type = R_BYTE;
    byte_res.out_char    = ch;
    byte_res.arg_index   = done_inc[IDX_W-1:0];
    byte_res.error_code  = E_NONE;
    byte_res.arg_count   = done_r[IDX_W-1:0];

    end_res              = '0;
    end_res.result_type  = R_END;
    end_res.arg_index    = done_inc[IDX_W-1:0];
    end_res.error_code   = E_NONE;
    end_res.arg_count    = done_inc[IDX_W-1:0];

    acc_res              = '0;
    acc_res.result_type  = R_ACCEPT;
    acc_res.error_code   = E_NONE;
    acc_res.arg_count    = done_f[IDX_W-1:0];
    acc_res.last         = 1'b1;

    // error code is filled in where the rejection is decided
    rej_res              = '0;
    rej_res.result_type  = R_REJECT;
    rej_res.error_code   = E_NONE;
    rej_res.arg_count    = done_r[IDX_W-1:0];
    rej_res.last         = 1'b1;
  end

  always_comb begin
    mode_nxt = mode_r;
    esc_nxt  = esc_r;
    has_nxt  = has_r;
    done_nxt = done_r;
    do_fin   = 1'b0;
    fin_zero = 1'b0;
    do_rej   = 1'b0;
    rej_zero = 1'b0;
    rej_code = E_NONE;
    so       = '0;

    case (mode_r)
      M_SKIP: begin
        if (nul) begin
          so.r0_vld = 1'b1;
          so.r0     = acc_res;
          done_nxt  = '0;
          esc_nxt   = 1'b0;
          has_nxt   = 1'b0;
        end else if (blank) begin
          mode_nxt = M_SKIP;
        end else if (quote) begin
          mode_nxt = M_QUOTED;
          esc_nxt  = 1'b0;
          has_nxt  = 1'b0;
        end else begin
          mode_nxt  = M_PLAIN;
          esc_nxt   = bslash;
          has_nxt   = 1'b1;
          so.r0_vld = 1'b1;
          so.r0     = byte_res;
        end
      end
      M_PLAIN: begin
        if (nul) begin
          do_fin   = 1'b1;
          fin_zero = 1'b1;
        end else if (esc_r) begin
          esc_nxt   = 1'b0;
          has_nxt   = 1'b1;
          so.r0_vld = 1'b1;
          so.r0     = byte_res;
        end else if (blank) begin
          do_fin = 1'b1;
        end else if (quote) begin
          do_rej   = 1'b1;
          rej_code = E_STRAY;
        end else begin
          esc_nxt   = bslash;
          has_nxt   = 1'b1;
          so.r0_vld = 1'b1;
          so.r0     = byte_res;
        end
      end
      M_QUOTED: begin
        if (nul) begin
          do_rej   = 1'b1;
          rej_zero = 1'b1;
          rej_code = E_MISSING;
        end else if (esc_r) begin
          esc_nxt   = 1'b0;
          has_nxt   = 1'b1;
          so.r0_vld = 1'b1;
          so.r0     = byte_res;
        end else if (quote) begin
          mode_nxt = M_AFTER;
        end else begin
          esc_nxt   = bslash;
          has_nxt   = 1'b1;
          so.r0_vld = 1'b1;
          so.r0     = byte_res;
        end
      end
      M_AFTER: begin
        if (nul) begin
          do_fin   = 1'b1;
          fin_zero = 1'b1;
        end else if (blank) begin
          do_fin = 1'b1;
        end else begin
          do_rej   = 1'b1;
          rej_code = E_AFTER;
        end
      end
      M_DROP: begin
        if (nul) begin
          mode_nxt = M_SKIP;
          esc_nxt  = 1'b0;
          has_nxt  = 1'b0;
          done_nxt = '0;
        end
      end
      default: begin
        mode_nxt = M_SKIP;
        esc_nxt  = 1'b0;
        has_nxt  = 1'b0;
        done_nxt = '0;
      end
    endcase

    // Close the argument: end mark if it holds bytes, then accept on NUL or limit.
    if (do_fin) begin
      esc_nxt   = 1'b0;
      has_nxt   = 1'b0;
      so.r0_vld = has_r || fin_zero || lim;
      so.r0     = has_r ? end_res : acc_res;
      so.r1_vld = has_r && (fin_zero || lim);
      so.r1     = acc_res;
      if (fin_zero || lim) begin
        mode_nxt = fin_zero ? M_SKIP : M_DROP;
        done_nxt = '0;
      end else begin
        mode_nxt = M_SKIP;
        done_nxt = done_f;
      end
    end

    if (do_rej) begin
      so.r0_vld         = 1'b1;
      so.r0             = rej_res;
      so.r0.error_code  = rej_code;
      mode_nxt          = rej_zero ? M_SKIP : M_DROP;
      esc_nxt           = 1'b0;
      has_nxt           = 1'b0;
      done_nxt          = '0;
    end

    if (!proc) begin
      so.r0_vld = 1'b0;
      so.r1_vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_SKIP;
      esc_r  <= 1'b0;
      has_r  <= 1'b0;
      done_r <= '0;
    end else if (proc) begin
      mode_r <= mode_nxt;
      esc_r  <= esc_nxt;
      has_r  <= has_nxt;
      done_r <= done_nxt;
    end
  end

  a_second_is_accept: assert property (@(posedge clk) disable iff (!rst_n)
    so.r1_vld |-> (so.r0.result_type == R_END) && (so.r1.result_type == R_ACCEPT))
    else $error("second result of an item is not end followed by accept");

  a_count_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    done_r < CNT_W'(MAX_ARGS))
    else $error("argument count reached the limit without closing the message");

  a_escape_in_arg: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> (mode_r == M_PLAIN) || (mode_r == M_QUOTED))
    else $error("escape pending outside an argument");

endmodule

FILE: hw/rtl/qat_outq.sv
// Result queue: takes up to two results a cycle, hands out one per pop.
// Depends on qat_pkg.
module qat_outq import qat_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  step_out_t push,
  input  logic      pop,
  output logic      room2,
  output logic      not_empty,
  output res_t      head
);

  res_t              mem_r [Q_DEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign not_empty = (cnt_r != '0);
  assign room2     = (cnt_r <= QCNT_W'(Q_DEPTH - 2));
  assign head      = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r + QPTR_W'(push.r0_vld) + QPTR_W'(push.r1_vld);
    rp_nxt  = rp_r + QPTR_W'(pop);
    cnt_nxt = cnt_r + QCNT_W'(push.r0_vld) + QCNT_W'(push.r1_vld) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.r0_vld) begin
      mem_r[wp_r] <= push.r0;
    end
    if (push.r1_vld) begin
      mem_r[wp_r + 1'b1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(Q_DEPTH))
    else $error("result queue overflow");

  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.r1_vld |-> push.r0_vld)
    else $error("second result pushed without the first");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (push.r0_vld && !pop) |=> not_empty)
    else $error("pushed result not visible");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty result queue");

endmodule

FILE: hw/rtl/quoted_argument_tokenizer.sv
// Path: an item passes the input register, then the result queue; where an item has a second
// result (argument end plus accept), it follows the first out of the queue.
// Throughput: one item per cycle while the result queue has room for two results; an item
// with two results leaves one result at a time, set by the single-result queue output port.
// Reset (rst_n low, synchronous): between arguments, counts cleared, queue empty.
// Top level of the tokenizer; depends on qat_pkg, qat_step and qat_outq.
module quoted_argument_tokenizer import qat_pkg::*; #(
  parameter int MAX_ARGS = MAX_ARGS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_ch,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_result_type,
  output logic [7:0]       out_out_char,
  output logic [IDX_W-1:0] out_arg_index,
  output logic [1:0]       out_error_code,
  output logic [IDX_W-1:0] out_arg_count,
  output logic             out_last
);

  logic       vld_r, vld_nxt;
  logic [7:0] ch_r;
  logic       proc, accept, pop, room2;
  step_out_t  so;
  res_t       head;

  // Process the held item once the queue can take both of its possible results.
  assign proc     = vld_r && room2;
  assign in_stall = vld_r && !room2;
  assign accept   = in_valid && !in_stall;
  assign vld_nxt  = accept || (vld_r && !proc);
  assign pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r <= in_ch;
    end
  end

  qat_step #(
    .MAX_ARGS (MAX_ARGS)
  ) u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .proc  (proc),
    .ch    (ch_r),
    .so    (so)
  );

  qat_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (so),
    .pop       (pop),
    .room2     (room2),
    .not_empty (out_valid),
    .head      (head)
  );

  assign out_result_type = head.result_type;
  assign out_out_char    = head.out_char;
  assign out_arg_index   = head.arg_index;
  assign out_error_code  = head.error_code;
  assign out_arg_count   = head.arg_count;
  assign out_last        = head.last;

endmodule

FILE: tb/quoted_argument_tokenizer_test.sv
// Self-checking testbench for quoted_argument_tokenizer: a directed byte table, arguments
// past the limit, then random messages, checked against an in-bench argument tokenizer model.
// Depends on qat_pkg and the quoted_argument_tokenizer RTL only.
module quoted_argument_tokenizer_test;
  import qat_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ARG_LIMIT   = MAX_ARGS_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;

  typedef struct {
    logic [7:0] ch;
    bit         typed;
    res_t       want;
  } dir_row_t;

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic [7:0]       in_ch     = '0;
  logic             out_stall = 1'b0;
  logic             in_stall;
  logic             out_valid;
  logic [1:0]       out_result_type;
  logic [7:0]       out_out_char;
  logic [IDX_W-1:0] out_arg_index;
  logic [1:0]       out_error_code;
  logic [IDX_W-1:0] out_arg_count;
  logic             out_last;

  // tokenizer state as the bench sees it
  mode_t            tok_mode;
  bit               tok_escaped;
  bit               tok_has_bytes;
  logic [CNT_W-1:0] tok_args;

  res_t     byte_tokens[$];
  res_t     tokens_due[$];
  res_t     oldest_token;
  dir_row_t dir_rows[$];
  int       fault_count   = 0;
  int       bytes_sent    = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       hold_asks     = 0;
  int       hold_done     = 0;
  int       hold_left     = 0;
  int       quiet_cycles  = 0;

  quoted_argument_tokenizer #(
    .MAX_ARGS(ARG_LIMIT)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_ch          (in_ch),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_type(out_result_type),
    .out_out_char   (out_out_char),
    .out_arg_index  (out_arg_index),
    .out_error_code (out_error_code),
    .out_arg_count  (out_arg_count),
    .out_last       (out_last)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic res_t make_result(rtype_t t, logic [7:0] c, logic [IDX_W-1:0] idx,
                                       err_t e, logic [IDX_W-1:0] cnt);
    res_t r;
    r.result_type = t;
    r.out_char    = c;
    r.arg_index   = idx;
    r.error_code  = e;
    r.arg_count   = cnt;
    r.last        = (t == R_ACCEPT) || (t == R_REJECT);
    return r;
  endfunction

  function automatic void restart_message(mode_t m);
    tok_mode      = m;
    tok_escaped   = 1'b0;
    tok_has_bytes = 1'b0;
    tok_args      = '0;
  endfunction

  function automatic void emit_arg_byte(logic [7:0] c);
    logic [CNT_W-1:0] idx;
    idx = tok_args + 1'b1;
    tok_has_bytes = 1'b1;
    byte_tokens.push_back(make_result(R_BYTE, c, idx[IDX_W-1:0], E_NONE,
                                      tok_args[IDX_W-1:0]));
  endfunction

  function automatic void reject_message(err_t e, bit at_nul);
    byte_tokens.push_back(make_result(R_REJECT, CH_NUL, '0, e, tok_args[IDX_W-1:0]));
    restart_message(at_nul ? M_SKIP : M_DROP);
  endfunction

  function automatic void close_argument(bit at_nul);
    if (tok_has_bytes) begin
      tok_args = tok_args + 1'b1;
      byte_tokens.push_back(make_result(R_END, CH_NUL, tok_args[IDX_W-1:0], E_NONE,
                                        tok_args[IDX_W-1:0]));
    end
    tok_escaped   = 1'b0;
    tok_has_bytes = 1'b0;
    if (at_nul) begin
      byte_tokens.push_back(make_result(R_ACCEPT, CH_NUL, '0, E_NONE, tok_args[IDX_W-1:0]));
      restart_message(M_SKIP);
    end else if (tok_args >= CNT_W'(ARG_LIMIT)) begin
      // argument limit reached: accept now, drop the rest of the message
      byte_tokens.push_back(make_result(R_ACCEPT, CH_NUL, '0, E_NONE, tok_args[IDX_W-1:0]));
      restart_message(M_DROP);
    end else begin
      tok_mode = M_SKIP;
    end
  endfunction

  function automatic void tokenize_byte(logic [7:0] c);
    bit blank;
    blank = (c == CH_SPACE) || (c == CH_TAB);
    case (tok_mode)
      M_SKIP: begin
        if (c == CH_NUL) begin
          byte_tokens.push_back(make_result(R_ACCEPT, CH_NUL, '0, E_NONE,
                                            tok_args[IDX_W-1:0]));
          restart_message(M_SKIP);
        end else if (blank) begin
        end else if (c == CH_QUOTE) begin
          tok_mode      = M_QUOTED;
          tok_escaped   = 1'b0;
          tok_has_bytes = 1'b0;
        end else begin
          tok_mode    = M_PLAIN;
          tok_escaped = (c == CH_BSLASH);
          emit_arg_byte(c);
        end
      end
      M_PLAIN: begin
        if (c == CH_NUL) begin
          close_argument(1'b1);
        end else if (tok_escaped) begin
          tok_escaped = 1'b0;
          emit_arg_byte(c);
        end else if (blank) begin
          close_argument(1'b0);
        end else if (c == CH_QUOTE) begin
          reject_message(E_STRAY, 1'b0);
        end else begin
          tok_escaped = (c == CH_BSLASH);
          emit_arg_byte(c);
        end
      end
      M_QUOTED: begin
        if (c == CH_NUL) begin
          reject_message(E_MISSING, 1'b1);
        end else if (tok_escaped) begin
          tok_escaped = 1'b0;
          emit_arg_byte(c);
        end else if (c == CH_QUOTE) begin
          tok_mode = M_AFTER;
        end else begin
          tok_escaped = (c == CH_BSLASH);
          emit_arg_byte(c);
        end
      end
      M_AFTER: begin
        if (c == CH_NUL) begin
          close_argument(1'b1);
        end else if (blank) begin
          close_argument(1'b0);
        end else begin
          reject_message(E_AFTER, 1'b0);
        end
      end
      default: begin
        if (c == CH_NUL) begin
          restart_message(M_SKIP);
        end
      end
    endcase
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endfunction

  function automatic logic [7:0] blank_byte();
    return ($urandom_range(1) == 0) ? CH_SPACE : CH_TAB;
  endfunction

  function automatic logic [7:0] text_byte(bit quoted);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(1, 255));
    end while (b == CH_QUOTE || b == CH_BSLASH ||
               (!quoted && (b == CH_SPACE || b == CH_TAB)));
    return b;
  endfunction

  // Offer one item, wait for it to be taken, then queue what it should produce.
  task automatic send_byte(logic [7:0] c, bit typed, res_t want);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_ch    <= c;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    byte_tokens.delete();
    tokenize_byte(c);
    if (typed) begin
      tokens_due.push_back(want);
    end else begin
      foreach (byte_tokens[i]) tokens_due.push_back(byte_tokens[i]);
    end
  endtask

  // Mostly well-formed messages with random content; some get one byte corrupted.
  task automatic send_message();
    logic [7:0] msg[$];
    int         kind;
    int         n_args;
    int         len;
    bit         quoted;
    kind   = $urandom_range(99);
    n_args = (kind < 10) ? $urandom_range(28, 36) : $urandom_range(0, 6);
    repeat ($urandom_range(0, 2)) msg.push_back(blank_byte());
    for (int a = 0; a < n_args; a++) begin
      quoted = ($urandom_range(3) == 0);
      len    = (n_args > 20) ? $urandom_range(1, 2) : $urandom_range(quoted ? 0 : 1, 6);
      if (quoted) begin
        msg.push_back(CH_QUOTE);
      end
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(7) == 0) begin
          msg.push_back(CH_BSLASH);
          msg.push_back(8'($urandom_range(1, 255)));
        end else begin
          msg.push_back(text_byte(quoted));
        end
      end
      if (quoted) begin
        msg.push_back(CH_QUOTE);
      end
      repeat ($urandom_range(1, 3)) msg.push_back(blank_byte());
    end
    if (kind >= 85 && msg.size() > 0) begin
      case ($urandom_range(2))
        0:       msg[$urandom_range(msg.size() - 1)] = CH_QUOTE;
        1:       msg[$urandom_range(msg.size() - 1)] = CH_BSLASH;
        default: msg[$urandom_range(msg.size() - 1)] = 8'($urandom_range(0, 255));
      endcase
    end
    msg.push_back(CH_NUL);
    foreach (msg[i]) send_byte(msg[i], 1'b0, '0);
  endtask

  // receiver: random stalls, plus a long hold-off whenever one is asked for
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_done) begin
      out_stall <= 1'b1;
      hold_done <= hold_done + 1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (tokens_due.size() == 0) begin
        $error("unexpected result: type %0d char %0d", out_result_type, out_out_char);
        fault_count++;
      end else begin
        oldest_token = tokens_due.pop_front();
        compare_field("result_type", oldest_token.result_type, out_result_type);
        compare_field("out_char", oldest_token.out_char, out_out_char);
        compare_field("arg_index", oldest_token.arg_index, out_arg_index);
        compare_field("error_code", oldest_token.error_code, out_error_code);
        compare_field("arg_count", oldest_token.arg_count, out_arg_count);
        compare_field("last", oldest_token.last, out_last);
      end
    end
  end

  // watchdog: count cycles in which neither channel moves an item
  initial begin
    wait (rst_n);
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $error("no item moved for %0d cycles, %0d results outstanding",
           QUIET_LIMIT, tokens_due.size());
    $display("quoted_argument_tokenizer_test NOT OK");
    $finish;
  end

  initial begin
    dir_rows.push_back(dir_row_t'{8'h00, 1'b1,
                       make_result(R_ACCEPT, CH_NUL, 5'd0, E_NONE, 5'd0)});
    dir_rows.push_back(dir_row_t'{8'h61, 1'b1,
                       make_result(R_BYTE, 8'h61, 5'd1, E_NONE, 5'd0)});
    dir_rows.push_back(dir_row_t'{8'hFF, 1'b1,
                       make_result(R_BYTE, 8'hFF, 5'd1, E_NONE, 5'd0)});
    dir_rows.push_back(dir_row_t'{CH_TAB,    1'b0, '0});
    // empty quoted argument, then a quoted one holding a blank and a protected quote
    dir_rows.push_back(dir_row_t'{CH_QUOTE,  1'b0, '0});
    dir_rows.push_back(dir_row_t'{CH_QUOTE,  1'b0, '0});
    dir_rows.push_back(dir_row_t'{CH_SPACE,  1'b0, '0});
    dir_rows.push_back(dir_row_t'{CH_QUOTE,  1'b0, '0});
    dir_rows.push_back(dir_row_t'{CH_SPACE,  1'b0, '0});
    dir_rows.push_back(dir_row_t'{CH_BSLASH, 1'b0, '0});
    dir_rows.push_back(dir_row_t'{CH_QUOTE,  1'b0, '0});
    dir_rows.push_back(dir_row_t'{CH_QUOTE,  1'b0, '0});
    dir_rows.push_back(dir_row_t'{CH_NUL,    1'b0, '0});
    // stray quote, then the rest of the message is dropped
    dir_rows.push_back(dir_row_t'{8'h62,     1'b0, '0});
    dir_rows.push_back(dir_row_t'{CH_QUOTE,  1'b1,
                       make_result(R_REJECT, CH_NUL, 5'd0, E_STRAY, 5'd0)});
    dir_rows.push_back(dir_row_t'{8'h41,     1'b0, '0});
    dir_rows.push_back(dir_row_t'{CH_NUL,    1'b0, '0});
    // text right after a closing quote
    dir_rows.push_back(dir_row_t'{CH_QUOTE,  1'b0, '0});
    dir_rows.push_back(dir_row_t'{8'h63,     1'b0, '0});
    dir_rows.push_back(dir_row_t'{CH_QUOTE,  1'b0, '0});
    dir_rows.push_back(dir_row_t'{8'h64,     1'b1,
                       make_result(R_REJECT, CH_NUL, 5'd0, E_AFTER, 5'd0)});
    dir_rows.push_back(dir_row_t'{CH_NUL,    1'b0, '0});
    // missing closing quote, ended by a protected zero
    dir_rows.push_back(dir_row_t'{CH_QUOTE,  1'b0, '0});
    dir_rows.push_back(dir_row_t'{CH_BSLASH, 1'b0, '0});
    dir_rows.push_back(dir_row_t'{CH_NUL,    1'b1,
                       make_result(R_REJECT, CH_NUL, 5'd0, E_MISSING, 5'd0)});
    // protected zero in an unquoted argument still ends the message
    dir_rows.push_back(dir_row_t'{CH_BSLASH, 1'b0, '0});
    dir_rows.push_back(dir_row_t'{CH_NUL,    1'b0, '0});

    restart_message(M_SKIP);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 15;
    recv_idle_pct <= 47;
    foreach (dir_rows[i]) send_byte(dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].want);
    // one-letter arguments past the limit: accept early, drop the tail
    for (int i = 0; i < ARG_LIMIT + 2; i++) begin
      send_byte(8'h41 + 8'(i), 1'b0, '0);
      send_byte(CH_SPACE, 1'b0, '0);
    end
    send_byte(CH_NUL, 1'b0, '0);

    hold_asks <= hold_asks + 1;
    while (bytes_sent < 500) send_message();

    send_idle_pct = 47;
    recv_idle_pct <= 15;
    while (bytes_sent < 1000) send_message();

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_asks <= hold_asks + 1;
    while (bytes_sent < 1500) send_message();

    in_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("quoted_argument_tokenizer_test OK");
    end else begin
      $display("quoted_argument_tokenizer_test NOT OK");
    end
    $finish;
  end

endmodule
